### rtl/lcfp_pkg.sv
// lcfp_pkg: shared types and constants for the length/checksum frame parser
// no dependencies

package lcfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned HDR_LEN     = 2;
  localparam int unsigned OVERHEAD    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_BAD_SUM  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [7:0] frame_checksum;
    logic [2:0] frame_status;
  } out_item_t;

endpackage

### rtl/length_checksum_frame_parser_core.sv
// length_checksum_frame_parser_core: byte-wise frame parser with 8-bit additive checksum
// depends on lcfp_pkg
//
// usage:
//   in channel (in_valid/in_stall/in_data) carries one received byte per item,
//   with end_of_buffer set on the final byte of a buffer.
//   out channel (out_valid/out_stall/out_data) carries zero or one result per
//   input item: a tentative payload byte (result_kind 0) or, on the final
//   byte, a frame verdict (result_kind 1) with id, length, checksum, status.
//   results are registered: a result enters the output register, or the skid
//   register while the output register holds an untaken result. throughput: one
//   byte per cycle while in_stall is low; the parse state is updated by a single
//   layer of logic in front of the result register. stall: a skid register behind
//   the output register keeps intake running while one result waits; in_stall rises
//   only when both hold results, and drops as soon as the receiver takes one.
//   reset: byte count, running sum, held id and length clear to zero and both
//   result registers empty. the count and sum also clear after each final byte.

module length_checksum_frame_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcfp_pkg::out_item_t out_data
);

  logic [lcfp_pkg::COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]                   running_sum_r, running_sum_nxt;
  logic [7:0]                   held_id_r, held_id_nxt;
  logic [7:0]                   held_length_r, held_length_nxt;

  lcfp_pkg::out_item_t out_item_r, out_item_nxt;
  lcfp_pkg::out_item_t skid_item_r, skid_item_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;

  logic                         accept;
  logic                         out_pop;
  logic                         has_result;
  lcfp_pkg::out_item_t          res;
  logic [lcfp_pkg::COUNT_W-1:0] total;
  logic [lcfp_pkg::COUNT_W-1:0] rel_pos;
  logic [lcfp_pkg::COUNT_W-1:0] expected_total;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign out_pop   = out_valid_r && !out_stall;

  assign total          = (byte_count_r == lcfp_pkg::COUNT_MAX) ? lcfp_pkg::COUNT_MAX
                                                                 : byte_count_r + 1'b1;
  assign rel_pos        = byte_count_r - lcfp_pkg::COUNT_W'(lcfp_pkg::HDR_LEN);
  assign expected_total = {1'b0, held_length_r} + lcfp_pkg::COUNT_W'(lcfp_pkg::OVERHEAD);

  // parse step
  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    held_id_nxt     = held_id_r;
    held_length_nxt = held_length_r;
    has_result      = 1'b0;
    res             = '0;
    if (accept) begin
      if (in_data.end_of_buffer) begin
        has_result      = 1'b1;
        res.result_kind = lcfp_pkg::KIND_VERDICT;
        byte_count_nxt  = '0;
        running_sum_nxt = '0;
        if (total < lcfp_pkg::COUNT_W'(lcfp_pkg::OVERHEAD)) begin
          res.frame_status = lcfp_pkg::ST_SHORT;
        end else begin
          res.frame_id       = held_id_r;
          res.frame_length   = held_length_r;
          res.frame_checksum = in_data.rx_byte;
          if (running_sum_r != in_data.rx_byte) begin
            res.frame_status = lcfp_pkg::ST_BAD_SUM;
          end else if (held_length_r > 8'(lcfp_pkg::MAX_PAYLOAD)) begin
            res.frame_status = lcfp_pkg::ST_TOO_LONG;
          end else if (total != expected_total) begin
            res.frame_status = lcfp_pkg::ST_MISMATCH;
          end else begin
            res.frame_status = lcfp_pkg::ST_OK;
          end
        end
      end else begin
        byte_count_nxt  = total;
        running_sum_nxt = running_sum_r + in_data.rx_byte;
        if (byte_count_r == '0) begin
          held_id_nxt = in_data.rx_byte;
        end else if (byte_count_r == lcfp_pkg::COUNT_W'(1)) begin
          held_length_nxt = in_data.rx_byte;
        end else if (rel_pos < {1'b0, held_length_r}) begin
          has_result        = 1'b1;
          res.result_kind   = lcfp_pkg::KIND_PAYLOAD;
          res.payload_byte  = in_data.rx_byte;
          res.payload_index = rel_pos[7:0];
        end
      end
    end
  end

  // output register plus skid
  always_comb begin
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_pop) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (has_result) begin
      if (!out_valid_r || out_pop) begin
        out_item_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_item_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_sum_r <= '0;
      held_id_r     <= '0;
      held_length_r <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      held_id_r     <= held_id_nxt;
      held_length_r <= held_length_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

endmodule
